### hw/rtl/irlfe_pkg.sv
// ----------------------------------------------------------------------------
// irlfe_pkg
// Shared types, constants and coding functions of the IR light frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package irlfe_pkg;

   // item function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // configuration register indexes
   localparam logic CSR_GROUP_ID    = 1'b0;
   localparam logic CSR_RANDOM_BITS = 1'b1;
   localparam int   CSR_INDEX_W     = 1;
   localparam int   CSR_DATA_W      = 5;

   localparam logic [11:0] CRC_POLY  = 12'h8F3;
   localparam logic [11:0] CRC_INIT  = 12'hC69;
   localparam logic [7:0]  MODE_BYTE = 8'h00;

   localparam int CODED_BYTES = 9;
   localparam int FRAME_W     = CODED_BYTES * 8;
   localparam int MSG_BYTES   = 7;

   // on-air bit positions
   localparam int CNT_W        = 7;
   localparam logic [CNT_W-1:0] PREAMBLE_BITS = 7'd16;
   localparam logic [CNT_W-1:0] SYNC_LOW_IDX  = 7'd16;
   localparam logic [CNT_W-1:0] SYNC_HIGH_IDX = 7'd17;
   localparam logic [CNT_W-1:0] PAYLOAD_IDX   = 7'd18;
   localparam logic [CNT_W-1:0] FRAME_BITS    = 7'd90;
   localparam logic [CNT_W-1:0] LAST_IDX      = 7'd89;

   typedef logic [FRAME_W-1:0] frame_type;

   typedef struct packed {
      logic       func;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [2:0] attack;
      logic [2:0] hold;
      logic [2:0] release_req;
   } item_type;

   typedef struct packed {
      logic line_level;
      logic sending;
      logic frame_end;
      logic accepted;
   } result_type;

   localparam logic [7:0] CODE_TABLE [64] = '{
      8'h21, 8'h35, 8'h2C, 8'h34, 8'h66, 8'h26, 8'hAC, 8'h24,
      8'h46, 8'h56, 8'h44, 8'h54, 8'h64, 8'h6D, 8'h4C, 8'h6C,
      8'h92, 8'hB2, 8'hA6, 8'hA2, 8'hB4, 8'h94, 8'h86, 8'h96,
      8'h42, 8'h62, 8'h2A, 8'h6A, 8'hB6, 8'h36, 8'h22, 8'h32,
      8'h31, 8'hB1, 8'h95, 8'hB5, 8'h91, 8'h99, 8'h85, 8'h89,
      8'hA5, 8'hA4, 8'h8C, 8'h84, 8'hA1, 8'hA9, 8'h8D, 8'hAD,
      8'h9A, 8'h8A, 8'h5A, 8'h4A, 8'h49, 8'h59, 8'h52, 8'h51,
      8'h25, 8'h2D, 8'h69, 8'h29, 8'h4D, 8'h45, 8'h61, 8'h65
   };

   // 6b8b line code
   function automatic logic [7:0] code6(input logic [5:0] v);
      return CODE_TABLE[v];
   endfunction

   // reflected CRC-12 over the coded message bytes, LSB first
   function automatic logic [11:0] crc12(input logic [MSG_BYTES*8-1:0] msg);
      logic [11:0] r;
      r = CRC_INIT;
      for (int i = 0; i < MSG_BYTES; i++) begin
         r = r ^ {4'h0, msg[i*8 +: 8]};
         for (int j = 0; j < 8; j++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/irlfe_req_if.sv
// ----------------------------------------------------------------------------
// irlfe_req_if
// Request channel: start and tick items.
// ----------------------------------------------------------------------------
`default_nettype none

interface irlfe_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [2:0] attack;
   logic [2:0] hold;
   logic [2:0] release_req;

   modport source (output valid, func, red, green, blue, attack, hold, release_req,
                   input ready);
   modport sink   (input valid, func, red, green, blue, attack, hold, release_req,
                   output ready);
endinterface

`default_nettype wire

### hw/rtl/irlfe_rsp_if.sv
// ----------------------------------------------------------------------------
// irlfe_rsp_if
// Response channel: one line-level result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface irlfe_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic sending;
   logic frame_end;
   logic accepted;

   modport source (output valid, line_level, sending, frame_end, accepted, input ready);
   modport sink   (input valid, line_level, sending, frame_end, accepted, output ready);
endinterface

`default_nettype wire

### hw/rtl/irlfe_frame_build.sv
// ----------------------------------------------------------------------------
// irlfe_frame_build
// Builds the nine coded frame bytes (CRC halves around the coded message).
// ----------------------------------------------------------------------------
`default_nettype none

module irlfe_frame_build (
   input  irlfe_pkg::item_type  item,
   input  logic [4:0]           group_id,
   input  logic [2:0]           random_bits,
   output irlfe_pkg::frame_type frame
);
   import irlfe_pkg::*;

   logic [MSG_BYTES*8-1:0] coded_msg;
   logic [11:0]            crc;

   always_comb begin
      coded_msg[0*8 +: 8] = code6(MODE_BYTE[5:0]);
      coded_msg[1*8 +: 8] = code6(item.green[7:2]);
      coded_msg[2*8 +: 8] = code6(item.red[7:2]);
      coded_msg[3*8 +: 8] = code6(item.blue[7:2]);
      coded_msg[4*8 +: 8] = code6({item.attack, random_bits});
      coded_msg[5*8 +: 8] = code6({item.release_req, item.hold});
      coded_msg[6*8 +: 8] = code6({1'b0, group_id});
   end

   assign crc   = crc12(coded_msg);
   assign frame = {code6(crc[11:6]), coded_msg, code6(crc[5:0])};

endmodule

`default_nettype wire

### hw/rtl/irlfe_tx_core.sv
// ----------------------------------------------------------------------------
// irlfe_tx_core
// Frame state and bit sequencer; registers one result per processed item.
// ----------------------------------------------------------------------------
`default_nettype none

module irlfe_tx_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  irlfe_pkg::item_type   item,
   input  irlfe_pkg::frame_type  frame,
   output irlfe_pkg::result_type result
);
   import irlfe_pkg::*;

   frame_type         frame_ff, frame_in;
   logic              frame_we;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   result_type        result_ff, result_in;
   logic [CNT_W-1:0]  bit_pos;
   logic              level;
   logic              fend;

   // level of the current on-air bit
   always_comb begin
      bit_pos = cnt_ff - PAYLOAD_IDX;
      if (cnt_ff < PREAMBLE_BITS) begin
         level = ~cnt_ff[0];            // 0x55 sent LSB first
      end else if (cnt_ff == SYNC_LOW_IDX) begin
         level = 1'b0;
      end else if (cnt_ff == SYNC_HIGH_IDX) begin
         level = 1'b1;
      end else if (cnt_ff < FRAME_BITS) begin
         level = frame_ff[bit_pos];
      end else begin
         level = 1'b0;                  // trailing low after a high last bit
      end
      fend = (cnt_ff >= FRAME_BITS) || ((cnt_ff == LAST_IDX) && !level);
   end

   always_comb begin
      frame_we  = 1'b0;
      frame_in  = frame;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      result_in = result_ff;
      if (step) begin
         result_in = '0;
         if (item.func == FUNC_START) begin
            if (!busy_ff) begin
               frame_we           = 1'b1;
               cnt_in             = '0;
               busy_in            = 1'b1;
               result_in.accepted = 1'b1;
            end
         end else if (busy_ff) begin
            result_in.sending    = 1'b1;
            result_in.line_level = level;
            result_in.frame_end  = fend;
            if (fend) begin
               busy_in = 1'b0;
               cnt_in  = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         busy_ff   <= 1'b0;
         result_ff <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         busy_ff   <= busy_in;
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_ff <= frame_in;
      end
   end

   assign result = result_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FRAME_BITS)
      else $error("bit counter past end of frame");

   a_end_clears_busy: assert property (@(posedge clock) disable iff (reset)
      result_ff.frame_end |-> !busy_ff && cnt_ff == '0)
      else $error("frame end left frame running");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      result_ff.accepted |-> busy_ff && cnt_ff == '0)
      else $error("accepted start did not open a frame");

   a_tick_sends: assert property (@(posedge clock) disable iff (reset)
      step && item.func == FUNC_TICK && busy_ff |=> result_ff.sending)
      else $error("tick during frame sent no bit");
`endif

endmodule

`default_nettype wire

### hw/rtl/ir_light_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// ir_light_frame_encoder_top
// IR light-band frame transmitter: 6b8b coding, CRC-12, bit sequencing.
// ----------------------------------------------------------------------------
// Takes one request per clock while not stalled and returns one response per
// request, in order. A request is held in an input register; the frame builder
// and bit sequencer then act on it and the response lands in the output
// register. Throughput is one item per cycle, set by the frame state update
// in the sequencer stage. Backpressure on the response side stalls both
// stages. A start item when idle codes and stores the nine frame bytes; each
// tick then yields one on-air bit of the 90-bit frame (plus one low bit when
// the last bit is high). CSR writes must happen while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_light_frame_encoder_top (
   input  logic                                clock,
   input  logic                                reset,
   irlfe_req_if.sink                           req_if,
   irlfe_rsp_if.source                         rsp_if,
   input  logic                                csr_we,
   input  logic [irlfe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [irlfe_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import irlfe_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       step;
   logic       req_take;
   logic [4:0] group_ff, group_in;
   logic [2:0] random_ff, random_in;
   frame_type  frame;
   result_type result;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign step         = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || out_free;
   assign req_take     = req_if.valid && req_if.ready;

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      group_in  = group_ff;
      random_in = random_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GROUP_ID:    group_in  = csr_wdata;
            CSR_RANDOM_BITS: random_in = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         group_ff     <= '0;
         random_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         group_ff     <= group_in;
         random_ff    <= random_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.func        <= req_if.func;
         in_item_ff.red         <= req_if.red;
         in_item_ff.green       <= req_if.green;
         in_item_ff.blue        <= req_if.blue;
         in_item_ff.attack      <= req_if.attack;
         in_item_ff.hold        <= req_if.hold;
         in_item_ff.release_req <= req_if.release_req;
      end
   end

   irlfe_frame_build u_frame_build (
      .item        (in_item_ff),
      .group_id    (group_ff),
      .random_bits (random_ff),
      .frame       (frame)
   );

   irlfe_tx_core u_tx_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .frame  (frame),
      .result (result)
   );

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.line_level = result.line_level;
   assign rsp_if.sending    = result.sending;
   assign rsp_if.frame_end  = result.frame_end;
   assign rsp_if.accepted   = result.accepted;

endmodule

`default_nettype wire
